/* hw/rtl/vm_pkg.sv */
// Shared types and constants of the voltmeter core.
package vm_pkg;

	// Field and datapath widths
	localparam int V_W        = 22;
	localparam int CODE_W     = 16;
	localparam int OFS_W      = 25;
	localparam int GAIN_W     = 24;
	localparam int WINCFG_W   = 11;
	localparam int FUNC_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int X_W        = 33;
	localparam int MA_W       = 33;
	localparam int MB_W       = 25;
	localparam int P_W        = 58;
	localparam int SH_W       = P_W - 32;
	localparam int SQ_W       = 43;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 72;

	typedef logic signed [V_W-1:0] volt_t;

	localparam volt_t V_MAX = 22'sh1FFFFF;
	localparam volt_t V_MIN = 22'sh200000;

	// Command codes carried in the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE     = 2'd0,
		FUNC_CLR_MINMAX = 2'd1,
		FUNC_HOLD_SET   = 2'd2,
		FUNC_HOLD_CLR   = 2'd3
	} func_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE   = 2'd0,
		CFG_WINDOW = 2'd1,
		CFG_OFFSET = 2'd2,
		CFG_GAIN   = 2'd3
	} cfg_idx_t;

	localparam logic MODE_DC = 1'b0;
	localparam logic MODE_AC = 1'b1;
	localparam logic KIND_DC = 1'b0;
	localparam logic KIND_AC = 1'b1;

	// Register values after reset
	localparam logic [WINCFG_W-1:0]    RST_WINDOW = 11'd100;
	localparam logic signed [OFS_W-1:0] RST_OFFSET = 25'sd9008225;
	localparam logic [GAIN_W-1:0]      RST_GAIN   = 24'd3653991;

	// Sequencer states
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_MUL  = 9'b000000010,
		ST_SAT  = 9'b000000100,
		ST_SQR  = 9'b000001000,
		ST_ACC  = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_SQRT = 9'b001000000,
		ST_RMS  = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

endpackage

/* hw/rtl/vm_cmpsub.sv */
// Shared compare and subtract unit for the divide and square root steps.
module vm_cmpsub #(
	parameter int W = 8
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic borrow;

	// Subtract with one extra bit; no borrow means a >= b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
	assign ge = ~borrow;

endmodule

/* hw/rtl/voltmeter_rms_min_max_core.sv */
// Voltmeter core: code scaling, DC min/max, AC RMS over a window with its min/max.
// Steps: a command is done on acceptance. A DC sample passes MUL, SAT and EMIT to the output register.
// An AC sample inside the window passes MUL, SAT, SQR and ACC; the sample that closes the window
// then passes DIV, SQRT, RMS and EMIT, the shared compare-subtract unit doing one quotient bit,
// then one root bit, per cycle. Throughput: one item at a time.
// Reset: asynchronous, active low; registers take their defaults, measurement state and output valid clear.
module voltmeter_rms_min_max_core import vm_pkg::*; #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [TDATA_IN_W-1:0]  s_tdata,   // adc_code[15:0]
	input  logic [FUNC_W-1:0]      s_tuser,   // func[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [TDATA_OUT_W-1:0] m_tdata,   // reading[21:0], minimum[43:22], maximum[65:44], zeros
	output logic                   m_tuser,   // result_kind
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (WIN_W > WINCFG_W) ? WIN_W : WINCFG_W;
	localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW);
	localparam int ROOT_W = (SUM_W + 1) / 2;
	localparam int DQ_W = 2 * ROOT_W;
	localparam int U_W = (WIN_W + 1 > ROOT_W + 2) ? WIN_W + 1 : ROOT_W + 2;
	localparam int IT_W = $clog2(DQ_W + 1);
	localparam int PAD_W = TDATA_OUT_W - 3 * V_W;

	state_t state_q;

	// Configuration registers
	logic                    mode_q;
	logic [WINCFG_W-1:0]     win_len_q;
	logic signed [OFS_W-1:0] ofs_q;
	logic [GAIN_W-1:0]       gain_q;

	// Measurement state
	logic [WIN_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	volt_t            last_v_q;
	volt_t            last_rms_q;
	volt_t            dc_min_q;
	volt_t            dc_max_q;
	volt_t            ac_min_q;
	volt_t            ac_max_q;
	logic             hold_q;

	// Datapath registers
	logic signed [X_W-1:0] x_q;
	logic signed [P_W-1:0] p_q;
	logic [DQ_W-1:0]       dq_q;
	logic [U_W-1:0]        rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [IT_W-1:0]       iter_q;
	logic                  kind_q;

	// Output register
	logic                   m_tvalid_q;
	logic [TDATA_OUT_W-1:0] m_tdata_q;
	logic                   m_tuser_q;

	logic s_acc;
	logic cfg_acc;
	func_t func;
	logic signed [X_W-1:0] x_in;

	logic [CMP_W-1:0] win_ext;
	logic [WIN_W-1:0] w_eff;

	logic signed [MA_W-1:0] ma;
	logic signed [MB_W-1:0] mb;
	logic signed [P_W-1:0]  prod;

	logic signed [SH_W-1:0] sh;
	logic                   v_over;
	logic                   v_under;
	volt_t                  v_sat;

	logic [SUM_W-1:0] sum_nx;
	logic [WIN_W-1:0] cnt_nx;

	logic [WIN_W:0]    div_sh;
	logic [ROOT_W+1:0] sqrt_sh;
	logic [ROOT_W+1:0] sqrt_trial;
	logic [U_W-1:0]    ua;
	logic [U_W-1:0]    ub;
	logic              u_ge;
	logic [U_W-1:0]    u_diff;

	volt_t rms;
	logic  out_free;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid & s_tready;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign func      = func_t'(s_tuser);
	assign out_free  = ~m_tvalid_q | m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Scale the code to Q16 and add the offset
	assign x_in = {s_tdata[CODE_W-1], s_tdata, 16'h0000}
		+ {{(X_W - OFS_W){ofs_q[OFS_W-1]}}, ofs_q};

	// Clamp the window length to 1..MAX_WINDOW
	assign win_ext = CMP_W'(win_len_q);
	always_comb begin
		if (win_len_q == '0) begin
			w_eff = WIN_W'(1);
		end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
			w_eff = WIN_W'(MAX_WINDOW);
		end else begin
			w_eff = win_ext[WIN_W-1:0];
		end
	end

	// Shared multiplier: gain scaling or squaring of the last voltage
	always_comb begin
		if (state_q == ST_SQR) begin
			ma = {{(MA_W - V_W){last_v_q[V_W-1]}}, last_v_q};
			mb = {{(MB_W - V_W){last_v_q[V_W-1]}}, last_v_q};
		end else begin
			ma = x_q;
			mb = {{(MB_W - GAIN_W){1'b0}}, gain_q};
		end
	end
	assign prod = P_W'(ma) * P_W'(mb);

	// Floor shift by 32, then saturate to 22 bits
	assign sh      = p_q[P_W-1:32];
	assign v_over  = ~sh[SH_W-1] & (sh[SH_W-2:V_W-1] != '0);
	assign v_under = sh[SH_W-1] & (sh[SH_W-2:V_W-1] != '1);
	always_comb begin
		if (v_over) begin
			v_sat = V_MAX;
		end else if (v_under) begin
			v_sat = V_MIN;
		end else begin
			v_sat = sh[V_W-1:0];
		end
	end

	assign sum_nx = sum_q + SUM_W'(p_q[SQ_W-1:0]);
	assign cnt_nx = cnt_q + WIN_W'(1);

	// Operands of the shared unit: divide step or root step
	assign div_sh     = {rem_q[WIN_W-1:0], dq_q[DQ_W-1]};
	assign sqrt_sh    = {rem_q[ROOT_W-1:0], dq_q[DQ_W-1:DQ_W-2]};
	assign sqrt_trial = {root_q, 2'b01};
	always_comb begin
		if (state_q == ST_DIV) begin
			ua = U_W'(div_sh);
			ub = U_W'(w_eff);
		end else begin
			ua = U_W'(sqrt_sh);
			ub = U_W'(sqrt_trial);
		end
	end

	vm_cmpsub #(
		.W (U_W)
	) u_cmpsub (
		.a    (ua),
		.b    (ub),
		.ge   (u_ge),
		.diff (u_diff)
	);

	// Saturate the root to the reading range
	always_comb begin
		if (root_q[ROOT_W-1:V_W-1] != '0) begin
			rms = V_MAX;
		end else begin
			rms = volt_t'({1'b0, root_q[V_W-2:0]});
		end
	end

	// Sequencer, configuration and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_DC;
			win_len_q  <= RST_WINDOW;
			ofs_q      <= RST_OFFSET;
			gain_q     <= RST_GAIN;
			cnt_q      <= '0;
			sum_q      <= '0;
			last_v_q   <= '0;
			last_rms_q <= '0;
			dc_min_q   <= '0;
			dc_max_q   <= '0;
			ac_min_q   <= '0;
			ac_max_q   <= '0;
			hold_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// Drop the output once taken, unless a new item replaces it
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						case (func)
							FUNC_CLR_MINMAX: begin
								dc_min_q <= last_v_q;
								dc_max_q <= last_v_q;
								ac_min_q <= last_rms_q;
								ac_max_q <= last_rms_q;
							end
							FUNC_HOLD_SET: hold_q <= 1'b1;
							FUNC_HOLD_CLR: hold_q <= 1'b0;
							default: begin
								if (!hold_q) begin
									state_q <= ST_MUL;
								end
							end
						endcase
					end
				end
				ST_MUL: state_q <= ST_SAT;
				ST_SAT: begin
					last_v_q <= v_sat;
					if (mode_q == MODE_DC) begin
						if (v_sat > dc_max_q) begin
							dc_max_q <= v_sat;
						end
						if (v_sat < dc_min_q) begin
							dc_min_q <= v_sat;
						end
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: state_q <= ST_ACC;
				ST_ACC: begin
					if (cnt_nx >= w_eff) begin
						cnt_q   <= '0;
						sum_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q   <= cnt_nx;
						sum_q   <= sum_nx;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (iter_q == IT_W'(1)) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (iter_q == IT_W'(1)) begin
						state_q <= ST_RMS;
					end
				end
				ST_RMS: begin
					last_rms_q <= rms;
					if (rms > ac_max_q) begin
						ac_max_q <= rms;
					end
					if (rms < ac_min_q) begin
						ac_min_q <= rms;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Register writes; mode and window restart the window
			if (cfg_acc) begin
				case (cfg_idx_t'(cfg_index))
					CFG_MODE: begin
						mode_q <= cfg_data[0];
						cnt_q  <= '0;
						sum_q  <= '0;
					end
					CFG_WINDOW: begin
						win_len_q <= cfg_data[WINCFG_W-1:0];
						cnt_q     <= '0;
						sum_q     <= '0;
					end
					CFG_OFFSET: ofs_q <= cfg_data[OFS_W-1:0];
					CFG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q <= x_in;
			end
			ST_MUL, ST_SQR: begin
				p_q <= prod;
			end
			ST_SAT: begin
				kind_q <= KIND_DC;
			end
			ST_ACC: begin
				dq_q   <= DQ_W'(sum_nx);
				rem_q  <= '0;
				iter_q <= IT_W'(DQ_W);
			end
			ST_DIV: begin
				// One quotient bit per cycle
				dq_q <= {dq_q[DQ_W-2:0], u_ge};
				if (iter_q == IT_W'(1)) begin
					rem_q  <= '0;
					root_q <= '0;
					iter_q <= IT_W'(ROOT_W);
				end else begin
					rem_q  <= u_ge ? u_diff : ua;
					iter_q <= iter_q - IT_W'(1);
				end
			end
			ST_SQRT: begin
				// One root bit per cycle
				rem_q  <= u_ge ? u_diff : ua;
				root_q <= {root_q[ROOT_W-2:0], u_ge};
				dq_q   <= {dq_q[DQ_W-3:0], 2'b00};
				iter_q <= iter_q - IT_W'(1);
			end
			ST_RMS: begin
				kind_q <= KIND_AC;
			end
			ST_EMIT: begin
				if (out_free) begin
					m_tuser_q <= kind_q;
					if (kind_q == KIND_AC) begin
						m_tdata_q <= {{PAD_W{1'b0}}, ac_max_q, ac_min_q, last_rms_q};
					end else begin
						m_tdata_q <= {{PAD_W{1'b0}}, dc_max_q, dc_min_q, last_v_q};
					end
				end
			end
			default: ;
		endcase
	end

	// The open window never reaches its length
	ap_cnt_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < w_eff)
		else $error("sample count reached window length");

	// Division remainder stays below the divisor
	ap_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < U_W'(w_eff)))
		else $error("division remainder out of range");

	// Minimum never passes maximum, and the AC minimum is never negative
	ap_min_max_order: assert property (@(posedge clk) disable iff (!arst_n)
		(dc_min_q <= dc_max_q) && (ac_min_q <= ac_max_q) && !ac_min_q[V_W-1])
		else $error("min/max order broken");

	// A finished result reaches the output register and the block returns to idle
	ap_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free) |=> (m_tvalid_q && state_q == ST_IDLE))
		else $error("result not delivered to output register");

endmodule

/* dv/tb.sv */
// Self-checking testbench of the voltmeter core with a built-in meter predictor.
`timescale 1ns / 100ps

module tb;
	import vm_pkg::*;

	localparam int          MAX_WIN     = 1024;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// Longest path through the core is the window close
	localparam int          SETTLE      = 100;

	typedef logic signed [CODE_W-1:0] code_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_word_t;

	typedef struct packed {
		func_t op;
		code_t code;
	} meter_item_t;

	typedef struct packed {
		logic  kind;
		volt_t reading;
		volt_t lo;
		volt_t hi;
	} meter_reading_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;   // adc_code[15:0]
	logic [FUNC_W-1:0]      s_tuser = '0;   // func[1:0]
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;        // reading[21:0], minimum[43:22], maximum[65:44]
	logic                   m_tuser;        // result_kind
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	voltmeter_rms_min_max_core #(.MAX_WINDOW(MAX_WIN)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// Items waiting for the driver and readings waiting for the core
	meter_item_t    items_to_send[$];
	meter_reading_t readings_due[$];

	int unsigned n_queued = 0;
	int unsigned n_accepted = 0;
	int unsigned n_dc_seen = 0;
	int unsigned n_ac_seen = 0;
	int unsigned n_cfg_writes = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned src_idle_pct = 10;
	int unsigned sink_idle_pct = 84;
	int unsigned stall_req = 0;
	int unsigned stall_ack = 0;
	int unsigned stall_left = 0;
	logic        in_taken = 1'b0;

	// Predictor copy of the registers and the meter state
	logic                    mode_reg = MODE_DC;
	logic [WINCFG_W-1:0]     win_reg = RST_WINDOW;
	logic signed [OFS_W-1:0] ofs_reg = RST_OFFSET;
	logic [GAIN_W-1:0]       gain_reg = RST_GAIN;
	int unsigned             acc_count = 0;
	longint                  sq_sum = 0;
	longint                  last_v = 0;
	longint                  last_rms = 0;
	longint                  dc_lo = 0;
	longint                  dc_hi = 0;
	longint                  ac_lo = 0;
	longint                  ac_hi = 0;
	logic                    held = 1'b0;

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// Advance the meter by one item and queue the reading it produces, if any
	task automatic meter_step(func_t op, code_t code);
		longint         v;
		longint         w;
		longint unsigned r;
		meter_reading_t due;
		case (op)
			FUNC_CLR_MINMAX: begin
				dc_lo = last_v;
				dc_hi = last_v;
				ac_lo = last_rms;
				ac_hi = last_rms;
			end
			FUNC_HOLD_SET: held = 1'b1;
			FUNC_HOLD_CLR: held = 1'b0;
			default: begin
				if (!held) begin
					v = (longint'(code) * 65536 + longint'(ofs_reg)) * longint'(gain_reg);
					v = v >>> 32;
					if (v > longint'(V_MAX))
						v = longint'(V_MAX);
					if (v < longint'(V_MIN))
						v = longint'(V_MIN);
					last_v = v;
					if (mode_reg == MODE_DC) begin
						if (v > dc_hi)
							dc_hi = v;
						if (v < dc_lo)
							dc_lo = v;
						due.kind = KIND_DC;
						due.reading = volt_t'(v);
						due.lo = volt_t'(dc_lo);
						due.hi = volt_t'(dc_hi);
						readings_due.push_back(due);
					end else begin
						w = longint'(win_reg);
						if (w == 0)
							w = 1;
						if (w > MAX_WIN)
							w = MAX_WIN;
						sq_sum += v * v;
						acc_count++;
						if (acc_count >= w) begin
							r = root_floor(longint'(unsigned'(sq_sum)) / w);
							if (r > longint'(V_MAX))
								r = longint'(V_MAX);
							last_rms = longint'(r);
							acc_count = 0;
							sq_sum = 0;
							if (last_rms > ac_hi)
								ac_hi = last_rms;
							if (last_rms < ac_lo)
								ac_lo = last_rms;
							due.kind = KIND_AC;
							due.reading = volt_t'(last_rms);
							due.lo = volt_t'(ac_lo);
							due.hi = volt_t'(ac_hi);
							readings_due.push_back(due);
						end
					end
				end
			end
		endcase
	endtask

	// Count cycles for the watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Offer the next item once the previous one has been taken
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				meter_item_t nxt;
				nxt = items_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.code;
				s_tuser <= nxt.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Hold off the receiver for a long stretch on request
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (stall_req != stall_ack) begin
			stall_left <= 300;
			stall_ack <= stall_req;
		end
	end

	// Drive the receiver ready
	always @(negedge clk)
		m_tready <= (stall_left == 0) && ($urandom_range(99) >= sink_idle_pct);

	// Watch all three channels, predict and check
	always @(posedge clk) begin : monitor
		meter_reading_t got;
		meter_reading_t want;
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.reading = m_tdata[V_W-1:0];
				got.lo = m_tdata[2*V_W-1:V_W];
				got.hi = m_tdata[3*V_W-1:2*V_W];
				if (got.kind == KIND_DC)
					n_dc_seen++;
				else
					n_ac_seen++;
				if (readings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected reading at %0t: kind %0d reading %0d min %0d max %0d",
							$realtime, got.kind, got.reading, got.lo, got.hi);
				end else begin
					want = readings_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch at %0t: expected kind %0d reading %0d min %0d max %0d",
								$realtime, want.kind, want.reading, want.lo, want.hi);
							$display("  got kind %0d reading %0d min %0d max %0d",
								got.kind, got.reading, got.lo, got.hi);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_cfg_writes++;
				case (cfg_idx_t'(cfg_index))
					CFG_MODE: begin
						mode_reg = cfg_data[0];
						acc_count = 0;
						sq_sum = 0;
					end
					CFG_WINDOW: begin
						win_reg = cfg_data[WINCFG_W-1:0];
						acc_count = 0;
						sq_sum = 0;
					end
					CFG_OFFSET: ofs_reg = cfg_data[OFS_W-1:0];
					default: gain_reg = cfg_data[GAIN_W-1:0];
				endcase
			end
			if (s_tvalid && s_tready) begin
				n_accepted++;
				meter_step(func_t'(s_tuser), code_t'(s_tdata));
			end
		end
	end

	// End the run on a timeout
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send(func_t op, int code);
		meter_item_t it;
		it.op = op;
		it.code = code_t'(code);
		items_to_send.push_back(it);
		n_queued++;
	endtask

	task automatic write_reg(cfg_idx_t idx, int value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= cfg_word_t'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every item is taken and every reading has come, then let the core settle
	task automatic wait_idle();
		while (n_accepted != n_queued || readings_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_meter(logic mode, int win, int ofs, int gain);
		write_reg(CFG_MODE, int'(mode));
		write_reg(CFG_WINDOW, win);
		write_reg(CFG_OFFSET, ofs);
		write_reg(CFG_GAIN, gain);
	endtask

	function automatic int rand_code();
		case ($urandom_range(9))
			0: return 32767;
			1: return -32768;
			2: return -1;
			default: return int'(code_t'($urandom));
		endcase
	endfunction

	// Queue mostly samples with occasional min/max resets and hold sequences
	task automatic queue_random_run(int n);
		int k;
		int r;
		k = 0;
		while (k < n) begin
			r = $urandom_range(99);
			if (r < 4) begin
				send(FUNC_CLR_MINMAX, rand_code());
			end else if (r < 7) begin
				send(FUNC_HOLD_SET, rand_code());
				repeat ($urandom_range(1, 3))
					send(FUNC_SAMPLE, rand_code());
				if ($urandom_range(1))
					send(FUNC_CLR_MINMAX, rand_code());
				send(FUNC_HOLD_CLR, rand_code());
			end else if (r < 8) begin
				send(FUNC_HOLD_CLR, rand_code());
			end else begin
				send(FUNC_SAMPLE, rand_code());
			end
			k++;
		end
	endtask

	function automatic int pick_offset();
		case ($urandom_range(2))
			0: return int'(RST_OFFSET);
			1: return int'($urandom_range(0, 33554431)) - 16777216;
			default: return int'($urandom_range(0, 2097151)) - 1048576;
		endcase
	endfunction

	function automatic int pick_gain();
		case ($urandom_range(2))
			0: return int'(RST_GAIN);
			1: return int'($urandom_range(2097152, 8388608));
			default: return int'($urandom_range(0, 16777215));
		endcase
	endfunction

	initial begin
		logic mode;
		int   win;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Reset settings: extremes of the code, commands, hold
		send(FUNC_SAMPLE, 0);
		send(FUNC_SAMPLE, 32767);
		send(FUNC_SAMPLE, -32768);
		send(FUNC_SAMPLE, -1);
		send(FUNC_CLR_MINMAX, 0);
		send(FUNC_HOLD_SET, 0);
		send(FUNC_SAMPLE, 12345);
		send(FUNC_CLR_MINMAX, -1);
		send(FUNC_HOLD_CLR, 0);
		send(FUNC_SAMPLE, 21845);
		send(FUNC_SAMPLE, -21846);
		wait_idle();

		// Saturate the voltage both ways, then a zero gain
		set_meter(MODE_DC, 100, 16777215, 16777215);
		send(FUNC_SAMPLE, 32767);
		wait_idle();
		write_reg(CFG_OFFSET, -16777216);
		send(FUNC_SAMPLE, -32768);
		wait_idle();
		write_reg(CFG_GAIN, 0);
		send(FUNC_SAMPLE, 1234);
		wait_idle();

		// Window of one with RMS overflow, then a zero window, then a short one
		set_meter(MODE_AC, 1, -16777216, 16777215);
		send(FUNC_SAMPLE, -32768);
		send(FUNC_SAMPLE, 100);
		send(FUNC_CLR_MINMAX, 0);
		wait_idle();
		set_meter(MODE_AC, 0, int'(RST_OFFSET), int'(RST_GAIN));
		send(FUNC_SAMPLE, 5);
		send(FUNC_SAMPLE, -5);
		wait_idle();
		write_reg(CFG_WINDOW, 3);
		send(FUNC_SAMPLE, 32767);
		send(FUNC_SAMPLE, -32768);
		send(FUNC_SAMPLE, 7);
		wait_idle();

		// Random phases over changing settings and idling regimes
		for (int p = 0; p < 8; p++) begin
			if (p == 3) begin
				src_idle_pct = 84;
				sink_idle_pct = 10;
			end else if (p == 6) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			mode = (p % 2 == 1) ? MODE_AC : MODE_DC;
			win = (p == 3) ? 0 : int'($urandom_range(1, 12));
			set_meter(mode, win, pick_offset(), pick_gain());
			if (p == 2)
				stall_req++;
			queue_random_run(25);
			wait_idle();
		end

		// Oversized window acts as the largest one
		set_meter(MODE_AC, 2047, int'(RST_OFFSET), int'(RST_GAIN));
		repeat (MAX_WIN + 5)
			send(FUNC_SAMPLE, rand_code());
		wait_idle();

		$display("covered %0d items and %0d register writes over DC, AC and hold sequences",
			n_accepted, n_cfg_writes);
		$display("checked %0d DC and %0d AC readings, %0d mismatches",
			n_dc_seen, n_ac_seen, mismatches);
		if (mismatches == 0 && readings_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
